// File: sv/i2c_bit_level_master_assert.svh
// Assertion macros used by the phase sequencer of the bit-level I2C master RTL.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Immediate implication checked on every clock edge outside reset.
`define I2CBM_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("i2c master check failed");
// Implication whose consequence is checked on the clock edge after the condition.
`define I2CBM_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("i2c master check failed");
`else
`define I2CBM_ASSERT_NOW(lbl, cond, cons)
`define I2CBM_ASSERT_NEXT(lbl, cond, cons)
`endif

`endif

// File: sv/i2cbm_pkg.sv
// Types, codes and constants of the bit-level I2C master.
package i2cbm_pkg;

    localparam int TIMEOUT_COUNTER_WIDTH_DEF = 16;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd100;

    // Command codes.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;

    // Sequence phases.
    localparam logic [4:0] PH_IDLE         = 5'd31;
    localparam logic [4:0] PH_STEP0        = 5'd0;
    localparam logic [4:0] PH_STEP1        = 5'd1;
    localparam logic [4:0] PH_STEP2        = 5'd2;
    localparam logic [4:0] PH_STEP3        = 5'd3;
    localparam logic [4:0] PH_RD_LAST_BIT  = 5'd24;
    localparam logic [4:0] PH_RD_ACK       = 5'd25;
    localparam logic [4:0] PH_RD_ACK_HI    = 5'd26;
    localparam logic [4:0] PH_RD_ACK_LO    = 5'd27;
    localparam logic [4:0] PH_WA_RELEASE   = 5'd0;
    localparam logic [4:0] PH_WA_SCL_HI    = 5'd1;
    localparam logic [4:0] PH_WA_POLL      = 5'd2;
    localparam logic [4:0] PH_WA_ACKED     = 5'd3;
    localparam logic [4:0] PH_WA_STOP_SDA  = 5'd4;
    localparam logic [4:0] PH_WA_STOP_SCL  = 5'd5;

    // Sub-steps of one data bit.
    localparam logic [1:0] SUB_DATA = 2'd0;
    localparam logic [1:0] SUB_HIGH = 2'd1;
    localparam logic [1:0] SUB_LOW  = 2'd2;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       ready_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_ok;
        logic       timed_out;
    } t_result;

endpackage

// File: sv/i2cbm_in_stage.sv
// Input register of the bit-level I2C master with its flow control.
module i2cbm_in_stage
    import i2cbm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_item i_item,
    input  logic  i_out_room,
    output logic  o_in_stall,
    output logic  o_step,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // The held item is processed whenever the result register has room.
    assign o_step     = r_valid & i_out_room;
    assign o_in_stall = r_valid & ~i_out_room;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_item;
        end
    end

endmodule

// File: sv/i2cbm_phase_fsm.sv
// Phase sequencer of the bit-level I2C master: bus state and command progress.
`include "i2c_bit_level_master_assert.svh"

module i2cbm_phase_fsm
    import i2cbm_pkg::*;
#(
    parameter int TIMEOUT_COUNTER_WIDTH = TIMEOUT_COUNTER_WIDTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_step,
    input  t_item       i_item,
    output t_result     o_result
);

    localparam int CW = (TIMEOUT_COUNTER_WIDTH > 16) ? TIMEOUT_COUNTER_WIDTH : 16;
    localparam logic [TIMEOUT_COUNTER_WIDTH-1:0] CNT_MAX = {TIMEOUT_COUNTER_WIDTH{1'b1}};

    logic [4:0]                       r_phase, n_phase;
    logic [2:0]                       r_cmd, n_cmd;
    logic [1:0]                       r_sub, n_sub;
    logic [2:0]                       r_bit, n_bit;
    logic [7:0]                       r_shift, n_shift;
    logic                             r_ack_choice, n_ack_choice;
    logic [TIMEOUT_COUNTER_WIDTH-1:0] r_wait_cnt, n_wait_cnt;
    logic                             r_scl, n_scl;
    logic                             r_sda, n_sda;
    logic [7:0]                       r_last_read, n_last_read;
    logic [15:0]                      r_timeout;

    logic                             w_active;
    logic [2:0]                       w_cmd;
    logic [4:0]                       w_ph;
    logic [4:0]                       w_next;
    logic [1:0]                       w_sub;
    logic [2:0]                       w_bit;
    logic                             w_fin;
    logic                             w_ack;
    logic                             w_tout;
    logic [TIMEOUT_COUNTER_WIDTH-1:0] w_cnt_inc;

    assign w_cnt_inc = (r_wait_cnt != CNT_MAX) ? r_wait_cnt + 1'b1 : r_wait_cnt;

    always_comb begin
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_sub        = r_sub;
        n_bit        = r_bit;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_wait_cnt   = r_wait_cnt;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_last_read  = r_last_read;
        w_active     = 1'b0;
        w_cmd        = r_cmd;
        w_ph         = r_phase;
        w_sub        = r_sub;
        w_bit        = r_bit;
        w_fin        = 1'b0;
        w_ack        = 1'b0;
        w_tout       = 1'b0;

        if (i_step) begin
            if (r_phase == PH_IDLE) begin
                // A new command takes its first bus action on the accepting phase.
                if (i_item.cmd_valid && (i_item.operation <= OP_WAIT)) begin
                    w_active = 1'b1;
                    w_cmd    = i_item.operation;
                    n_cmd    = i_item.operation;
                    w_ph     = PH_STEP0;
                    w_sub    = SUB_DATA;
                    w_bit    = 3'd0;
                    if (i_item.operation == OP_WRITE) begin
                        n_shift = i_item.write_data;
                    end
                    if (i_item.operation == OP_READ) begin
                        n_ack_choice = i_item.send_ack;
                    end
                end
            end else begin
                w_active = 1'b1;
            end
        end

        w_next = w_ph + 5'd1;

        if (w_active) begin
            case (w_cmd)
                OP_START: begin
                    if (w_ph == PH_STEP0) begin
                        n_sda = 1'b1;
                    end else if (w_ph == PH_STEP1) begin
                        n_scl = 1'b1;
                    end else if (w_ph == PH_STEP2) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                        w_fin = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (w_ph == PH_STEP0) begin
                        n_sda = 1'b0;
                    end else if (w_ph == PH_STEP1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                        w_fin = 1'b1;
                    end
                end
                OP_WRITE: begin
                    case (w_sub)
                        SUB_DATA: n_sda = n_shift[LAST_BIT - w_bit];
                        SUB_HIGH: n_scl = 1'b1;
                        default: begin
                            n_scl = 1'b0;
                            w_fin = (w_bit == LAST_BIT);
                        end
                    endcase
                    n_sub = (w_sub == SUB_LOW) ? SUB_DATA : w_sub + 2'd1;
                    n_bit = (w_sub == SUB_LOW) ? w_bit + 3'd1 : w_bit;
                end
                OP_READ: begin
                    if (w_ph == PH_STEP0) begin
                        n_sda   = 1'b1;
                        n_shift = 8'h00;
                    end else if (w_ph <= PH_RD_LAST_BIT) begin
                        case (w_sub)
                            SUB_DATA: n_scl = 1'b1;
                            SUB_HIGH: n_shift = {r_shift[6:0], i_item.sda_in};
                            default:  n_scl = 1'b0;
                        endcase
                        n_sub = (w_sub == SUB_LOW) ? SUB_DATA : w_sub + 2'd1;
                        n_bit = (w_sub == SUB_LOW) ? w_bit + 3'd1 : w_bit;
                    end else if (w_ph == PH_RD_ACK) begin
                        n_sda = ~r_ack_choice;
                    end else if (w_ph == PH_RD_ACK_HI) begin
                        n_scl = 1'b1;
                    end else if (w_ph == PH_RD_ACK_LO) begin
                        n_scl = 1'b0;
                    end else begin
                        n_sda       = 1'b1;
                        n_last_read = r_shift;
                        w_fin       = 1'b1;
                    end
                end
                default: begin
                    if (w_ph == PH_WA_RELEASE) begin
                        n_sda      = 1'b1;
                        n_wait_cnt = '0;
                    end else if (w_ph == PH_WA_SCL_HI) begin
                        n_scl = 1'b1;
                    end else if (w_ph == PH_WA_POLL) begin
                        if (!i_item.sda_in) begin
                            w_next = PH_WA_ACKED;
                        end else begin
                            n_wait_cnt = w_cnt_inc;
                            if ((CW'(w_cnt_inc) > CW'(r_timeout)) || (w_cnt_inc == CNT_MAX)) begin
                                w_next = PH_WA_STOP_SDA;
                            end else begin
                                w_next = PH_WA_POLL;
                            end
                        end
                    end else if (w_ph == PH_WA_ACKED) begin
                        n_scl = 1'b0;
                        w_fin = 1'b1;
                        w_ack = 1'b1;
                    end else if (w_ph == PH_WA_STOP_SDA) begin
                        n_sda = 1'b0;
                    end else if (w_ph == PH_WA_STOP_SCL) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda  = 1'b1;
                        w_fin  = 1'b1;
                        w_tout = 1'b1;
                    end
                end
            endcase
            n_phase = w_fin ? PH_IDLE : w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cmd        <= OP_START;
            r_sub        <= SUB_DATA;
            r_bit        <= 3'd0;
            r_shift      <= 8'h00;
            r_ack_choice <= 1'b0;
            r_wait_cnt   <= '0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_last_read  <= 8'h00;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cmd        <= n_cmd;
            r_sub        <= n_sub;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_wait_cnt   <= n_wait_cnt;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_last_read  <= n_last_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    assign o_result.scl_out   = n_scl;
    assign o_result.sda_out   = n_sda;
    assign o_result.ready_res = (n_phase == PH_IDLE);
    assign o_result.done_res  = w_fin;
    assign o_result.read_data = n_last_read;
    assign o_result.ack_ok    = w_ack;
    assign o_result.timed_out = w_tout;

    // A finishing phase always leaves the sequencer idle.
    `I2CBM_ASSERT_NOW(a_done_means_idle, i_step && w_fin, n_phase == PH_IDLE)
    // A wait ack ends either acknowledged or timed out, never both.
    `I2CBM_ASSERT_NOW(a_ack_xor_tout, i_step, !(w_ack && w_tout))
    // Without a processed item the sequence does not move.
    `I2CBM_ASSERT_NEXT(a_hold_on_stall, !i_step, $stable(r_phase) && $stable(r_scl))
    // A start sequence never runs past its fourth phase.
    `I2CBM_ASSERT_NOW(a_start_bounded, (r_phase != PH_IDLE) && (r_cmd == OP_START),
        r_phase <= PH_STEP3)

endmodule

// File: sv/i2cbm_out_stage.sv
// Result register of the bit-level I2C master.
module i2cbm_out_stage
    import i2cbm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_out_stall,
    output logic    o_room,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // Room exists when the register is empty or its result leaves this edge.
    assign o_room      = ~r_valid | ~i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: sv/i2c_bit_level_master.sv
// Top level of the bit-level I2C master: input register, phase sequencer, result register.
//
// Every input transaction is one bus phase tick. It carries the sampled SDA level and,
// when cmd_valid is set while the master is idle, a command: start, stop, write byte,
// read byte with ack or nack, or wait for ack. Commands given while busy are ignored.
// Each tick yields exactly one output transaction with the SCL and SDA levels to drive,
// the idle flag, the done pulse, the last read byte and the wait-ack outcome.
//
// Input acceptance reaches the output transaction through the input register, then the
// phase logic, which feeds the result register. Throughput is one transaction per cycle
// while the receiver does not stall, as the phase state updates on every processed item.
//
// The configuration register ack_timeout_phases is written through i_cfg_wr_en and
// i_cfg_wr_data at any clock edge with the enable high; write it only while idle.
//
// Synchronous active-low reset releases both lines high, leaves the sequencer idle,
// clears the last read byte and restores the timeout to its reset value of 100.
// When the receiver stalls, the result register holds and the input side stalls once
// its register is occupied, so no transaction is lost or repeated.
module i2c_bit_level_master
    import i2cbm_pkg::*;
#(
    parameter int TIMEOUT_COUNTER_WIDTH = TIMEOUT_COUNTER_WIDTH_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd_valid,
    input  logic [2:0]  i_operation,
    input  logic [7:0]  i_write_data,
    input  logic        i_send_ack,
    input  logic        i_sda_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_ready_res,
    output logic        o_done_res,
    output logic [7:0]  o_read_data,
    output logic        o_ack_ok,
    output logic        o_timed_out
);

    t_item   w_in_item;
    t_item   w_held_item;
    t_result w_next_result;
    t_result w_out_result;
    logic    w_step;
    logic    w_out_room;

    assign w_in_item.cmd_valid  = i_cmd_valid;
    assign w_in_item.operation  = i_operation;
    assign w_in_item.write_data = i_write_data;
    assign w_in_item.send_ack   = i_send_ack;
    assign w_in_item.sda_in     = i_sda_in;

    i2cbm_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_in_item),
        .i_out_room (w_out_room),
        .o_in_stall (o_in_stall),
        .o_step     (w_step),
        .o_item     (w_held_item)
    );

    i2cbm_phase_fsm #(
        .TIMEOUT_COUNTER_WIDTH (TIMEOUT_COUNTER_WIDTH)
    ) u_phase_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_step),
        .i_item        (w_held_item),
        .o_result      (w_next_result)
    );

    i2cbm_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step),
        .i_result    (w_next_result),
        .i_out_stall (i_out_stall),
        .o_room      (w_out_room),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_result)
    );

    assign o_scl_out   = w_out_result.scl_out;
    assign o_sda_out   = w_out_result.sda_out;
    assign o_ready_res = w_out_result.ready_res;
    assign o_done_res  = w_out_result.done_res;
    assign o_read_data = w_out_result.read_data;
    assign o_ack_ok    = w_out_result.ack_ok;
    assign o_timed_out = w_out_result.timed_out;

endmodule
